// ===== rtl/core/rsm_pkg.sv =====
// Shared package for the reservoir sampler core.
// Holds the sizes, the hash constants, the controller state and the command and status types.
// No dependencies.
`timescale 1ns / 1ps

package rsm_pkg;

    // Reservoir size and the widths that follow from it.
    localparam int unsigned CAPACITY = 4096;
    localparam int unsigned ADDR_W   = $clog2(CAPACITY);
    localparam int unsigned FILL_W   = $clog2(CAPACITY + 1);

    // Field widths of one transaction.
    localparam int unsigned COUNT_W = 64;
    localparam int unsigned SLOT_W  = 12;
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned LAB_W   = 16;

    // Stream data widths, rounded up to whole bytes.
    localparam int unsigned IN_DATA_W  = ((SLOT_W + WORD_W + LAB_W + 1 + 7) / 8) * 8;
    localparam int unsigned OUT_DATA_W =
        ((1 + SLOT_W + COUNT_W + 1 + WORD_W + LAB_W + 1 + 7) / 8) * 8;

    // Iteration counter for the bit-serial multiply and remainder.
    localparam int unsigned STEP_W = $clog2(COUNT_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(COUNT_W - 1);

    // SplitMix64 finalizer constants.
    localparam logic [COUNT_W-1:0] MIX_GOLDEN = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [COUNT_W-1:0] MIX_C1     = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [COUNT_W-1:0] MIX_C2     = 64'h94d0_49bb_1331_11eb;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_CHECK,
        S_MUL1,
        S_PREP2,
        S_MUL2,
        S_PREP3,
        S_MOD,
        S_FINISH
    } t_state;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_INC,
        DP_DIRECT,
        DP_PREP1,
        DP_PREP2,
        DP_PREP3,
        DP_MUL,
        DP_MOD,
        DP_READ,
        DP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic mode;     // captured transaction is a read-back
        logic filling;  // offer count is still within the reservoir size
    } t_dp_status;

endpackage

// ===== rtl/core/rsm_ctrl.sv =====
// Controller state machine of the reservoir sampler core.
// Sequences capture, read-back, direct fill, hashing, remainder and result load; depends on rsm_pkg.
`timescale 1ns / 1ps

module rsm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    input  rsm_pkg::t_dp_status i_status,
    output rsm_pkg::t_dp_cmd    o_cmd
);
    import rsm_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !r_out_valid || i_m_tready;

    // State, iteration counter and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        n_step     = '0;
        o_cmd.op   = DP_NOP;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.op = DP_CAPTURE;
                    n_state  = S_START;
                end
            end
            S_START: begin
                if (i_status.mode) begin
                    o_cmd.op = DP_READ;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.op = DP_INC;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.filling) begin
                    o_cmd.op = DP_DIRECT;
                    n_state  = S_FINISH;
                end else begin
                    o_cmd.op = DP_PREP1;
                    n_state  = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.op = DP_MUL;
                n_step   = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_step  = '0;
                    n_state = S_PREP2;
                end
            end
            S_PREP2: begin
                o_cmd.op = DP_PREP2;
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.op = DP_MUL;
                n_step   = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_step  = '0;
                    n_state = S_PREP3;
                end
            end
            S_PREP3: begin
                o_cmd.op = DP_PREP3;
                n_state  = S_MOD;
            end
            S_MOD: begin
                o_cmd.op = DP_MOD;
                n_step   = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_step  = '0;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.op = DP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output valid sets on a result load and clears when the receiver takes the result.
    always_comb begin
        if (o_cmd.op == DP_FINISH) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

`ifndef SYNTHESIS
    // A result is never loaded over one that is still waiting.
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == DP_FINISH) |-> (!r_out_valid || i_m_tready))
        else $error("result loaded over a waiting result");

    // The iteration counter runs only inside the serial phases.
    a_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_MUL1 && r_state != S_MUL2 && r_state != S_MOD) |-> (r_step == '0))
        else $error("iteration counter active outside serial phase");

    // A captured transaction always leaves the idle state next.
    a_capture_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == DP_CAPTURE) |=> (r_state == S_START))
        else $error("capture did not start processing");
`endif

endmodule

// ===== rtl/core/rsm_dp.sv =====
// Datapath of the reservoir sampler core: counters, serial multiply and remainder unit,
// sample store and result register. Depends on rsm_pkg.
`timescale 1ns / 1ps

module rsm_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [rsm_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                           i_s_tuser,
    input  rsm_pkg::t_dp_cmd               i_cmd,
    output rsm_pkg::t_dp_status            o_status,
    output logic [rsm_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import rsm_pkg::*;

    localparam int unsigned MEM_W = WORD_W + LAB_W + 1;

    // Captured transaction.
    logic              r_mode;
    logic [SLOT_W-1:0] r_rslot;
    logic [WORD_W-1:0] r_word;
    logic [LAB_W-1:0]  r_lab;
    logic              r_phase;

    // Persistent state.
    logic [COUNT_W-1:0] r_count;
    logic [FILL_W-1:0]  r_fill;

    // Serial arithmetic registers.
    logic [COUNT_W-1:0] r_acc, n_acc;
    logic [COUNT_W-1:0] r_a, n_a;
    logic [COUNT_W-1:0] r_b, n_b;

    // Sample store and its registered read port.
    logic [MEM_W-1:0] r_mem [CAPACITY];
    logic [MEM_W-1:0] r_rd;

    logic [OUT_DATA_W-1:0] r_res;

    logic [COUNT_W-1:0] mix_z;
    logic [COUNT_W:0]   rem_try;
    logic [COUNT_W:0]   rem_diff;
    logic               taken;
    logic               rd_valid;
    logic               grow;
    logic [SLOT_W-1:0]  res_slot;
    logic [MEM_W-1:0]   rd_fields;
    logic               op_finish;

    assign op_finish = (i_cmd.op == DP_FINISH);
    assign taken     = !r_mode && (r_acc < COUNT_W'(CAPACITY));
    assign grow      = r_acc >= COUNT_W'(r_fill);
    assign rd_valid  = r_mode && (32'(r_rslot) < 32'(r_fill));
    assign res_slot  = taken ? SLOT_W'(r_acc) : '0;
    assign rd_fields = rd_valid ? r_rd : '0;

    assign mix_z    = r_count + MIX_GOLDEN;
    assign rem_try  = {r_acc, r_b[COUNT_W-1]};
    assign rem_diff = rem_try - {1'b0, r_count};

    assign o_status.mode    = r_mode;
    assign o_status.filling = (r_count <= COUNT_W'(CAPACITY));

    // Offer count saturates; fill level tracks the highest slot written plus one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_fill  <= '0;
        end else begin
            if (i_cmd.op == DP_INC && r_count != '1) begin
                r_count <= r_count + 1'b1;
            end
            if (op_finish && taken && grow) begin
                r_fill <= FILL_W'(r_acc) + 1'b1;
            end
        end
    end

    // Capture of the accepted transaction.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_CAPTURE) begin
            r_mode  <= i_s_tuser;
            r_rslot <= i_s_tdata[SLOT_W-1:0];
            r_word  <= i_s_tdata[SLOT_W +: WORD_W];
            r_lab   <= i_s_tdata[SLOT_W + WORD_W +: LAB_W];
            r_phase <= i_s_tdata[SLOT_W + WORD_W + LAB_W];
        end
    end

    // Shared serial unit: shift-add multiply, restoring remainder, hash mixing and direct slot choice.
    always_comb begin
        n_acc = r_acc;
        n_a   = r_a;
        n_b   = r_b;
        unique case (i_cmd.op)
            DP_DIRECT: begin
                n_acc = r_count - 1'b1;
            end
            DP_PREP1: begin
                n_acc = '0;
                n_a   = mix_z ^ (mix_z >> 30);
                n_b   = MIX_C1;
            end
            DP_PREP2: begin
                n_acc = '0;
                n_a   = r_acc ^ (r_acc >> 27);
                n_b   = MIX_C2;
            end
            DP_PREP3: begin
                n_acc = '0;
                n_b   = r_acc ^ (r_acc >> 31);
            end
            DP_MUL: begin
                n_acc = r_acc + (r_b[0] ? r_a : '0);
                n_a   = r_a << 1;
                n_b   = r_b >> 1;
            end
            DP_MOD: begin
                n_acc = rem_diff[COUNT_W] ? rem_try[COUNT_W-1:0] : rem_diff[COUNT_W-1:0];
                n_b   = r_b << 1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    // Sample store: written when an offer is taken, read for a read-back.
    always_ff @(posedge i_clk) begin
        if (op_finish && taken) begin
            r_mem[r_acc[ADDR_W-1:0]] <= {r_phase, r_lab, r_word};
        end
        if (i_cmd.op == DP_READ) begin
            r_rd <= r_mem[ADDR_W'(r_rslot)];
        end
    end

    // Result register, packed taken, slot, count, read_valid, word, lab, phase from bit 0.
    always_ff @(posedge i_clk) begin
        if (op_finish) begin
            r_res <= OUT_DATA_W'({rd_fields, rd_valid, r_count, res_slot, taken});
        end
    end

    assign o_m_tdata = r_res;

`ifndef SYNTHESIS
    // The fill level never exceeds the reservoir size.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= CAPACITY)
        else $error("fill level beyond capacity");

    // The offer count never moves backward.
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_count >= $past(r_count)))
        else $error("offer count decreased");

    // The fill level changes only when a result is loaded.
    a_fill_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op != DP_FINISH) |=> $stable(r_fill))
        else $error("fill level changed outside result load");
`endif

endmodule

// ===== rtl/core/reservoir_sampler_splitmix_core.sv =====
// A read-back passes capture, a store read and the result load; an offer while the
// reservoir fills passes capture, count increment, direct slot choice and result load;
// a later offer adds two serial multiplies of the hash and a serial remainder in the
// shared arithmetic unit. One transaction at a time: the next is accepted in the cycle
// after the result is loaded, while that result may still wait in the output register.
// Reset (synchronous, active low) clears the count, fill level and controller state only.
`timescale 1ns / 1ps

module reservoir_sampler_splitmix_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // tdata: read_slot[11:0], sample_word[75:12], lab_id[91:76], preparation[92], zeros
    input  logic [rsm_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: mode
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // tdata: taken[0], slot[12:1], query_count[76:13], read_valid[77], read_word[141:78],
    //        read_lab[157:142], read_phase[158], zero
    output logic [rsm_pkg::OUT_DATA_W-1:0] o_m_tdata
);
    import rsm_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // Controller.
    rsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath.
    rsm_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .i_cmd     (cmd),
        .o_status  (status),
        .o_m_tdata (o_m_tdata)
    );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the reservoir sampler core.
// Depends on rsm_pkg and reservoir_sampler_splitmix_core with its rsm_ctrl and rsm_dp.
// Offers and read-backs are streamed through both ports and every result is checked.
`timescale 1ns / 1ps

module testbench;

    import rsm_pkg::*;

    // Meaning of the tuser bit on the input stream.
    localparam logic MODE_OFFER = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // Receiver hold-off length and the number of random items after the directed ones.
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 1290;
    localparam int PHASE_ITEMS    = 300;
    localparam int DRAIN_CYCLES   = 250;
    localparam int REPORT_LIMIT   = 100;

    typedef struct packed {
        logic              mode;
        logic [SLOT_W-1:0] read_slot;
        logic [WORD_W-1:0] sample_word;
        logic [LAB_W-1:0]  lab_id;
        logic              preparation;
    } t_sample_req;

    typedef struct packed {
        logic               taken;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] query_count;
        logic               read_valid;
        logic [WORD_W-1:0]  read_word;
        logic [LAB_W-1:0]   read_lab;
        logic               read_phase;
    } t_sample_res;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    reservoir_sampler_splitmix_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    // Stimulus and expectation stores.
    t_sample_req sample_requests[$];
    t_sample_res pending_results[$];

    // Shadow state of the sampler.
    logic [COUNT_W-1:0] offer_total;
    logic [FILL_W-1:0]  filled_slots;
    logic [WORD_W-1:0]  shadow_word[CAPACITY];
    logic [LAB_W-1:0]   shadow_lab[CAPACITY];
    logic               shadow_phase[CAPACITY];

    int          error_count = 0;
    int          accepted_in = 0;
    logic        s_accepted = 1'b0;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          hold_left = 0;
    int          hold_mark[2];
    int          hold_index = 0;
    int          gen_offers = 0;
    t_sample_req drive_req;

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // SplitMix64 finalizer applied to the offer count.
    function automatic logic [COUNT_W-1:0] splitmix_finalize(input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] z;
        z = n + MIX_GOLDEN;
        z = (z ^ (z >> 30)) * MIX_C1;
        z = (z ^ (z >> 27)) * MIX_C2;
        return z ^ (z >> 31);
    endfunction

    // Works out the result of one accepted transaction and updates the shadow reservoir.
    task automatic reservoir_predict(input t_sample_req req, output t_sample_res res);
        logic [COUNT_W-1:0] pick;
        res = '0;
        if (req.mode == MODE_OFFER) begin
            if (offer_total != '1) begin
                offer_total = offer_total + 1;
            end
            if (offer_total <= COUNT_W'(CAPACITY)) begin
                pick = offer_total - 1;
            end else begin
                pick = splitmix_finalize(offer_total) % offer_total;
            end
            if (pick < COUNT_W'(CAPACITY)) begin
                shadow_word[pick[ADDR_W-1:0]]  = req.sample_word;
                shadow_lab[pick[ADDR_W-1:0]]   = req.lab_id;
                shadow_phase[pick[ADDR_W-1:0]] = req.preparation;
                if (pick >= COUNT_W'(filled_slots)) begin
                    filled_slots = FILL_W'(pick + 1);
                end
                res.taken = 1'b1;
                res.slot  = pick[SLOT_W-1:0];
            end
            res.query_count = offer_total;
        end else begin
            res.query_count = offer_total;
            if (FILL_W'(req.read_slot) < filled_slots) begin
                res.read_valid = 1'b1;
                res.read_word  = shadow_word[req.read_slot];
                res.read_lab   = shadow_lab[req.read_slot];
                res.read_phase = shadow_phase[req.read_slot];
            end
        end
    endtask

    // Prints one line per mismatch, up to a limit, and counts every one.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < REPORT_LIMIT) begin
            $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
        end
        error_count++;
    endtask

    // Appends one request at the tail of the stimulus queue.
    task automatic add_request(input t_sample_req req);
        sample_requests.insert(sample_requests.size(), req);
    endtask

    // Queues one offer; the read slot field is noise that the block ignores.
    task automatic queue_offer(input logic [WORD_W-1:0] word, input logic [LAB_W-1:0] lab,
                               input logic prep, input logic [SLOT_W-1:0] noise);
        add_request('{MODE_OFFER, noise, word, lab, prep});
        gen_offers++;
    endtask

    // Queues one read-back with random content in the ignored fields.
    task automatic queue_read(input logic [SLOT_W-1:0] slot);
        add_request('{MODE_READ, slot, {$urandom, $urandom}, LAB_W'($urandom), 1'($urandom)});
    endtask

    // Random payload, now and then one of the extremes.
    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Idle rates follow the number of accepted transactions in three repeating phases.
    always_comb begin
        case ((accepted_in / PHASE_ITEMS) % 3)
            0: begin
                tx_idle_pct = 27;
                rx_idle_pct = 72;
            end
            1: begin
                tx_idle_pct = 72;
                rx_idle_pct = 27;
            end
            default: begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
    end

    // Input driver: presents the next queued request once the current one is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_accepted) begin
            if (sample_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                drive_req = sample_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= IN_DATA_W'({drive_req.preparation, drive_req.lab_id,
                                        drive_req.sample_word, drive_req.read_slot});
                s_tuser  <= drive_req.mode;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Output side: random backpressure plus long hold-offs at two points of the run.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_index < 2 && accepted_in >= hold_mark[hold_index]) begin
            m_tready   <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_index <= hold_index + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor: predicts on each input transaction and checks each output transaction.
    always @(posedge i_clk) begin
        t_sample_req req;
        t_sample_res want;
        t_sample_res got;
        if (!i_rst_n) begin
            s_accepted <= 1'b0;
        end else begin
            s_accepted <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                req.mode        = s_tuser;
                req.read_slot   = s_tdata[11:0];
                req.sample_word = s_tdata[75:12];
                req.lab_id      = s_tdata[91:76];
                req.preparation = s_tdata[92];
                reservoir_predict(req, want);
                pending_results.insert(pending_results.size(), want);
                accepted_in <= accepted_in + 1;
            end
            if (m_tvalid && m_tready) begin
                got.taken       = m_tdata[0];
                got.slot        = m_tdata[12:1];
                got.query_count = m_tdata[76:13];
                got.read_valid  = m_tdata[77];
                got.read_word   = m_tdata[141:78];
                got.read_lab    = m_tdata[157:142];
                got.read_phase  = m_tdata[158];
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata[63:0], '0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.taken !== want.taken)
                        report_mismatch("taken", 64'(got.taken), 64'(want.taken));
                    if (got.slot !== want.slot)
                        report_mismatch("slot", 64'(got.slot), 64'(want.slot));
                    if (got.query_count !== want.query_count)
                        report_mismatch("query_count", got.query_count, want.query_count);
                    if (got.read_valid !== want.read_valid)
                        report_mismatch("read_valid", 64'(got.read_valid),
                                        64'(want.read_valid));
                    if (got.read_word !== want.read_word)
                        report_mismatch("read_word", got.read_word, want.read_word);
                    if (got.read_lab !== want.read_lab)
                        report_mismatch("read_lab", 64'(got.read_lab), 64'(want.read_lab));
                    if (got.read_phase !== want.read_phase)
                        report_mismatch("read_phase", 64'(got.read_phase),
                                        64'(want.read_phase));
                end
            end
        end
    end

    // Stimulus build, reset and end of run.
    initial begin
        offer_total  = '0;
        filled_slots = '0;

        // Directed part: field extremes, both modes, reads of the first slots.
        queue_offer('0, '0, 1'b0, '0);
        queue_offer('1, '1, 1'b1, '1);
        add_request('{MODE_READ, 12'd0, '1, '1, 1'b1});
        add_request('{MODE_READ, 12'd1, '0, '0, 1'b0});
        queue_offer(64'h8000_0000_0000_0001, 16'h8001, 1'b0, 12'h800);
        queue_offer(64'h5555_5555_5555_5555, 16'haaaa, 1'b1, 12'h555);
        queue_read(12'd3);
        queue_read(12'd2);
        queue_read(12'd0);

        // Random offers mixed with reads of written, unwritten and extreme slots.
        repeat (RANDOM_ITEMS) begin
            if ($urandom_range(3) != 0) begin
                queue_offer(random_word(), LAB_W'($urandom), 1'($urandom), SLOT_W'($urandom));
            end else begin
                case ($urandom_range(7))
                    0: queue_read('0);
                    1: queue_read('1);
                    2: queue_read(SLOT_W'($urandom));
                    default: queue_read(SLOT_W'($urandom_range(gen_offers - 1)));
                endcase
            end
        end

        // One hold-off early in the run, one around its middle.
        hold_mark[0] = 60;
        hold_mark[1] = sample_requests.size() / 2;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Wait until all requests are taken and all results have arrived.
        do begin
            @(posedge i_clk);
            #1;
        end while (sample_requests.size() != 0 || s_tvalid || pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog for a run that hangs.
    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
